>>> rtl/strided_packbits_rle_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Strided PackBits decoder assertion macros
// Shared concurrent assertion forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef STRIDED_PACKBITS_RLE_DECODER_UNIT_MACROS_SVH
`define STRIDED_PACKBITS_RLE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define SPRLE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPRLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sprle_pkg.sv
// ----------------------------------------------------------------------------
// Strided PackBits decoder package
// Widths, register map, parser phases and the parser-to-address stage record.
// ----------------------------------------------------------------------------
package sprle_pkg;

   localparam int CsrAddrW  = 3;
   localparam int CsrDataW  = 32;
   localparam int StrideW   = 3;
   localparam int ByteW     = 8;
   localparam int PlaneW    = 2;
   localparam int IndexW    = 24;
   localparam int RunW      = 8;
   localparam int OutAddrW  = 24;
   localparam int TailW     = RunW + StrideW;
   localparam int FullAddrW = IndexW + StrideW + 1;
   localparam int WideW     = 64;

   localparam logic [StrideW-1:0] StrideReset = 3'd1;
   localparam logic               CsrRegStride = 1'b0;
   localparam logic [IndexW-1:0]  IndexMax = {IndexW{1'b1}};
   localparam logic [RunW:0]      RunBase = 9'd257;
   localparam logic [RunW-1:0]    LiteralRun = 8'd1;
   localparam logic [ByteW-1:0]   RunCtrlMin = 8'd128;

   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_LIT  = 2'd1,
      PH_RUN  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [PlaneW-1:0] plane;
      logic [ByteW-1:0]  value;
      logic [RunW-1:0]   run;
      logic [IndexW-1:0] index;
      logic [TailW-1:0]  tail;
   } emit_type;

endpackage

>>> rtl/sprle_channels.sv
// ----------------------------------------------------------------------------
// Strided PackBits decoder channels
// Valid/ready interfaces for the compressed byte requests and the results.
// ----------------------------------------------------------------------------
interface sprle_req_if;
   logic                         valid;
   logic                         ready;
   logic [sprle_pkg::ByteW-1:0]  in_byte;
   logic [sprle_pkg::PlaneW-1:0] plane;
   logic                         last;

   modport source (output valid, output in_byte, output plane, output last, input ready);
   modport sink   (input valid, input in_byte, input plane, input last, output ready);
endinterface

interface sprle_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sprle_pkg::OutAddrW-1:0] out_addr;
   logic [sprle_pkg::ByteW-1:0]    out_value;
   logic [sprle_pkg::RunW-1:0]     run_length;
   logic                           out_of_range;

   modport source (output valid, output out_addr, output out_value, output run_length,
                   output out_of_range, input ready);
   modport sink   (input valid, input out_addr, input out_value, input run_length,
                   input out_of_range, output ready);
endinterface

>>> rtl/strided_packbits_rle_decoder_unit.sv
// ----------------------------------------------------------------------------
// Strided PackBits run-length decoder
// Takes one compressed byte per cycle unless the result side stalls, and issues
// one result per literal byte or run value, with the strided destination
// address of its first element. Throughput is one request per clock when not
// stalled, set by the parser state update. A result passes the parser stage
// register, then the address multiply and range check. Control bytes give no
// result. The stride register at offset 0 may only be written while idle.
// ----------------------------------------------------------------------------
module strided_packbits_rle_decoder_unit #(
   parameter int ADDR_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   sprle_req_if.sink                        req,
   sprle_rsp_if.source                      rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sprle_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [sprle_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [sprle_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic [sprle_pkg::StrideW-1:0]  stride_ff;
   logic [sprle_pkg::StrideW-1:0]  stride_in;

   sprle_pkg::phase_type           phase_ff;
   sprle_pkg::phase_type           phase_in;
   logic [sprle_pkg::RunW-1:0]     lit_left_ff;
   logic [sprle_pkg::RunW-1:0]     lit_left_in;
   logic [sprle_pkg::RunW-1:0]     pend_run_ff;
   logic [sprle_pkg::RunW-1:0]     pend_run_in;
   logic [sprle_pkg::IndexW-1:0]   elem_idx_ff;
   logic [sprle_pkg::IndexW-1:0]   elem_idx_in;

   logic                           emit_valid;
   sprle_pkg::emit_type            emit_data;
   logic [sprle_pkg::RunW-1:0]     lit_dec;
   logic [sprle_pkg::RunW-1:0]     run_m1;
   logic [sprle_pkg::IndexW:0]     idx_sum;

   logic                           a_valid_ff;
   logic                           a_valid_in;
   sprle_pkg::emit_type            a_data_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [sprle_pkg::OutAddrW-1:0] rsp_addr_ff;
   logic [sprle_pkg::ByteW-1:0]    rsp_value_ff;
   logic [sprle_pkg::RunW-1:0]     rsp_run_ff;
   logic                           rsp_oor_ff;

   logic [sprle_pkg::FullAddrW-1:0] addr_full;
   logic [sprle_pkg::FullAddrW-1:0] end_full;
   logic [sprle_pkg::WideW-1:0]     end_wide;
   logic                            oor;

   logic req_fire;
   logic a_ready;
   logic b_ready;
   logic csr_wr;

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      stride_in = stride_ff;
      if (csr_wr && (csr_paddr[2] == sprle_pkg::CsrRegStride)) begin
         stride_in = csr_pwdata[sprle_pkg::StrideW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == sprle_pkg::CsrRegStride) begin
         csr_prdata = sprle_pkg::CsrDataW'(stride_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= sprle_pkg::StrideReset;
      end else begin
         stride_ff <= stride_in;
      end
   end

   // handshake
   assign b_ready   = !rsp_valid_ff || rsp.ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req.ready = a_ready;
   assign req_fire  = req.valid && a_ready;

   // parser
   assign lit_dec = lit_left_ff - sprle_pkg::RunW'(lit_left_ff != '0);

   always_comb begin
      phase_in    = phase_ff;
      lit_left_in = lit_left_ff;
      pend_run_in = pend_run_ff;
      emit_valid  = 1'b0;
      emit_data.plane = req.plane;
      emit_data.value = req.in_byte;
      emit_data.run   = sprle_pkg::LiteralRun;
      emit_data.index = elem_idx_ff;
      case (phase_ff)
         sprle_pkg::PH_LIT: begin
            emit_valid  = 1'b1;
            lit_left_in = lit_dec;
            if (lit_dec == '0) begin
               phase_in = sprle_pkg::PH_CTRL;
            end
         end
         sprle_pkg::PH_RUN: begin
            emit_valid     = 1'b1;
            emit_data.run  = pend_run_ff;
            pend_run_in    = '0;
            phase_in       = sprle_pkg::PH_CTRL;
         end
         default: begin
            if (req.in_byte < sprle_pkg::RunCtrlMin) begin
               lit_left_in = req.in_byte + sprle_pkg::LiteralRun;
               phase_in    = sprle_pkg::PH_LIT;
            end else begin
               pend_run_in = sprle_pkg::RunW'(sprle_pkg::RunBase - {1'b0, req.in_byte});
               phase_in    = sprle_pkg::PH_RUN;
            end
         end
      endcase

      run_m1         = emit_data.run - sprle_pkg::LiteralRun;
      emit_data.tail = sprle_pkg::TailW'(run_m1) * sprle_pkg::TailW'(stride_ff);

      idx_sum     = {1'b0, elem_idx_ff} + (sprle_pkg::IndexW + 1)'(emit_data.run);
      elem_idx_in = elem_idx_ff;
      if (emit_valid) begin
         elem_idx_in = idx_sum[sprle_pkg::IndexW] ? sprle_pkg::IndexMax
                                                  : idx_sum[sprle_pkg::IndexW-1:0];
      end

      if (req.last) begin
         phase_in    = sprle_pkg::PH_CTRL;
         lit_left_in = '0;
         pend_run_in = '0;
         elem_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sprle_pkg::PH_CTRL;
         lit_left_ff <= '0;
         pend_run_ff <= '0;
         elem_idx_ff <= '0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         lit_left_ff <= lit_left_in;
         pend_run_ff <= pend_run_in;
         elem_idx_ff <= elem_idx_in;
      end
   end

   // parser stage register
   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = emit_valid;
      end else if (b_ready) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit_valid) begin
         a_data_ff <= emit_data;
      end
   end

   // address and range check
   always_comb begin
      addr_full = sprle_pkg::FullAddrW'(a_data_ff.index) * sprle_pkg::FullAddrW'(stride_ff)
                + sprle_pkg::FullAddrW'(a_data_ff.plane);
      end_full  = addr_full + sprle_pkg::FullAddrW'(a_data_ff.tail);
      end_wide  = sprle_pkg::WideW'(end_full);
      oor       = (end_wide >> ADDR_BITS) != '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_ready) begin
         rsp_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         rsp_addr_ff  <= addr_full[sprle_pkg::OutAddrW-1:0];
         rsp_value_ff <= a_data_ff.value;
         rsp_run_ff   <= a_data_ff.run;
         rsp_oor_ff   <= oor;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_addr     = rsp_addr_ff;
   assign rsp.out_value    = rsp_value_ff;
   assign rsp.run_length   = rsp_run_ff;
   assign rsp.out_of_range = rsp_oor_ff;

endmodule

>>> rtl/sprle_checker.sv
// ----------------------------------------------------------------------------
// Strided PackBits decoder checker
// Port-level properties of the decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "strided_packbits_rle_decoder_unit_macros.svh"

module sprle_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sprle_pkg::OutAddrW-1:0] rsp_out_addr,
   input logic [sprle_pkg::ByteW-1:0]    rsp_out_value,
   input logic [sprle_pkg::RunW-1:0]     rsp_run_length,
   input logic                           rsp_out_of_range
);

   `SPRLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_addr) && $stable(rsp_out_value)
      && $stable(rsp_run_length) && $stable(rsp_out_of_range),
      "result changed while stalled")
   `SPRLE_ASSERT_NOW(a_run_range, clock, reset, rsp_valid,
      (rsp_run_length != 8'd0) && (rsp_run_length <= 8'd129), "run length out of range")
   `SPRLE_ASSERT_NOW(a_stall_cause, clock, reset, req_valid && !req_ready,
      rsp_valid && !rsp_ready, "request stalled without a blocked result")

endmodule

bind strided_packbits_rle_decoder_unit sprle_checker u_sprle_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_out_addr     (rsp.out_addr),
   .rsp_out_value    (rsp.out_value),
   .rsp_run_length   (rsp.run_length),
   .rsp_out_of_range (rsp.out_of_range)
);

>>> bench/strided_packbits_rle_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strided PackBits decoder testbench
// Drives compressed byte requests into the decoder with random gaps and
// result stalls. A write tracker decodes the same byte stream and keeps the
// strided writes that are still due; each result is checked against the
// oldest one. The stride register is swept between request phases.
// ----------------------------------------------------------------------------
module strided_packbits_rle_decoder_unit_test;

   localparam int AddrBits    = 24;
   localparam int DrainCycles = 8;
   localparam int QuietLimit  = 4000;
   localparam logic [sprle_pkg::CsrAddrW-1:0] StrideOffset =
      sprle_pkg::CsrAddrW'(4 * int'(sprle_pkg::CsrRegStride));

   class plane_write_tracker;
      typedef struct {
         logic [sprle_pkg::OutAddrW-1:0] addr;
         logic [sprle_pkg::ByteW-1:0]    value;
         logic [sprle_pkg::RunW-1:0]     run;
         logic                           oor;
      } write_type;

      logic [sprle_pkg::StrideW-1:0] stride;
      sprle_pkg::phase_type          phase;
      logic [sprle_pkg::RunW-1:0]    literals_left;
      logic [sprle_pkg::RunW-1:0]    run_pending;
      logic [sprle_pkg::IndexW-1:0]  index;
      write_type                     writes_due[$];
      int                            failures;

      function new();
         stride   = sprle_pkg::StrideReset;
         failures = 0;
         clear();
      endfunction

      function void clear();
         phase         = sprle_pkg::PH_CTRL;
         literals_left = '0;
         run_pending   = '0;
         index         = '0;
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) begin
            $display("ERROR %0t: %s", $realtime, what);
         end
      endfunction

      function void issue(logic [sprle_pkg::PlaneW-1:0] plane,
                          logic [sprle_pkg::ByteW-1:0] value,
                          logic [sprle_pkg::RunW-1:0] run);
         logic [63:0] start_addr;
         logic [63:0] end_addr;
         logic [63:0] next_index;
         write_type   w;
         start_addr = 64'(plane) + 64'(index) * 64'(stride);
         end_addr   = start_addr + (64'(run) - 64'd1) * 64'(stride);
         next_index = 64'(index) + 64'(run);
         w.addr     = start_addr[sprle_pkg::OutAddrW-1:0];
         w.value    = value;
         w.run      = run;
         w.oor      = (end_addr >> AddrBits) != 64'd0;
         writes_due.push_back(w);
         index = (next_index > 64'(sprle_pkg::IndexMax)) ? sprle_pkg::IndexMax
                                                          : next_index[sprle_pkg::IndexW-1:0];
      endfunction

      function void take_byte(logic [sprle_pkg::ByteW-1:0] b,
                              logic [sprle_pkg::PlaneW-1:0] plane, logic last);
         case (phase)
            sprle_pkg::PH_LIT: begin
               issue(plane, b, sprle_pkg::LiteralRun);
               if (literals_left != 0) literals_left = literals_left - 1'b1;
               if (literals_left == 0) phase = sprle_pkg::PH_CTRL;
            end
            sprle_pkg::PH_RUN: begin
               issue(plane, b, run_pending);
               run_pending = '0;
               phase       = sprle_pkg::PH_CTRL;
            end
            default: begin
               if (b < sprle_pkg::RunCtrlMin) begin
                  literals_left = b + 1'b1;
                  phase         = sprle_pkg::PH_LIT;
               end else begin
                  run_pending = sprle_pkg::RunW'(sprle_pkg::RunBase - {1'b0, b});
                  phase       = sprle_pkg::PH_RUN;
               end
            end
         endcase
         if (last) clear();
      endfunction

      function void check_write(logic [sprle_pkg::OutAddrW-1:0] addr,
                                logic [sprle_pkg::ByteW-1:0] value,
                                logic [sprle_pkg::RunW-1:0] run, logic oor);
         write_type w;
         if (writes_due.size() == 0) begin
            flag($sformatf("unexpected write addr=%h value=%h run=%0d oor=%b",
                           addr, value, run, oor));
            return;
         end
         w = writes_due.pop_front();
         if (w.addr !== addr || w.value !== value || w.run !== run || w.oor !== oor) begin
            flag($sformatf({"write exp addr=%h value=%h run=%0d oor=%b, ",
                            "got addr=%h value=%h run=%0d oor=%b"},
                           w.addr, w.value, w.run, w.oor, addr, value, run, oor));
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [sprle_pkg::CsrAddrW-1:0] csr_paddr;
   logic [sprle_pkg::CsrDataW-1:0] csr_pwdata;
   logic [sprle_pkg::CsrDataW-1:0] csr_prdata;
   logic                           csr_pready;

   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   plane_write_tracker tracker;

   sprle_req_if req();
   sprle_rsp_if rsp();

   strided_packbits_rle_decoder_unit #(
      .ADDR_BITS(AddrBits)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 59;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 59;
         end
         default: begin
            send_idle_pct  = 35;
            recv_stall_pct = 35;
         end
      endcase
   endtask

   task automatic send_byte(input logic [sprle_pkg::ByteW-1:0] b,
                            input logic [sprle_pkg::PlaneW-1:0] plane,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.in_byte <= b;
      req.plane   <= plane;
      req.last    <= last;
      do @(posedge clock); while (!req.ready);
      tracker.take_byte(b, plane, last);
   endtask

   // hold requests off until every due write has come back
   task automatic await_writes();
      req.valid <= 1'b0;
      do @(posedge clock); while (tracker.writes_due.size() != 0);
   endtask

   task automatic csr_access(input logic write, input logic [sprle_pkg::CsrAddrW-1:0] addr,
                             input logic [sprle_pkg::CsrDataW-1:0] data,
                             output logic [sprle_pkg::CsrDataW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_stride(input logic [sprle_pkg::StrideW-1:0] s);
      logic [sprle_pkg::CsrDataW-1:0] rd;
      await_writes();
      repeat (DrainCycles) @(posedge clock);
      csr_access(1'b1, StrideOffset, sprle_pkg::CsrDataW'(s), rd);
      tracker.stride = s;
      csr_access(1'b0, StrideOffset, '0, rd);
      if (rd[sprle_pkg::StrideW-1:0] !== s) begin
         tracker.flag($sformatf("stride readback exp %0d got %0d", s,
                                rd[sprle_pkg::StrideW-1:0]));
      end
   endtask

   // well-formed literal and run groups, with noise bytes and cut segments
   task automatic send_random(input int n_items);
      int                           sent;
      int                           pick;
      int                           count;
      int                           stop;
      int                           last_at;
      logic [sprle_pkg::ByteW-1:0]  ctrl;
      logic [sprle_pkg::PlaneW-1:0] plane;
      sent  = 0;
      plane = sprle_pkg::PlaneW'($urandom);
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_byte(sprle_pkg::ByteW'($urandom), sprle_pkg::PlaneW'($urandom),
                      $urandom_range(99) < 30);
            sent++;
         end else begin
            if (pick < 52) begin
               pick = $urandom_range(99);
               if (pick < 75)      ctrl = sprle_pkg::ByteW'($urandom_range(0, 7));
               else if (pick < 97) ctrl = sprle_pkg::ByteW'($urandom_range(8, 40));
               else                ctrl = 8'd127;
               count = int'(ctrl) + 1;
            end else begin
               ctrl  = sprle_pkg::ByteW'($urandom_range(128, 255));
               count = 1;
            end
            stop    = count;
            last_at = ($urandom_range(99) < 12) ? count : -1;
            if ($urandom_range(99) < 4) begin
               stop    = $urandom_range(0, count);
               last_at = stop;
            end
            for (int i = 0; i <= stop; i++) begin
               send_byte((i == 0) ? ctrl : sprle_pkg::ByteW'($urandom),
                         ($urandom_range(99) < 5) ? sprle_pkg::PlaneW'($urandom) : plane,
                         i == last_at);
            end
            sent += stop + 1;
            if (last_at >= 0) plane = sprle_pkg::PlaneW'($urandom);
         end
      end
   endtask

   // result side
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            tracker.check_write(rsp.out_addr, rsp.out_value, rsp.run_length,
                                rsp.out_of_range);
         end
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("strided_packbits_rle_decoder_unit_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      logic [sprle_pkg::CsrDataW-1:0] rd;
      logic [sprle_pkg::StrideW-1:0]  strides[6];
      tracker        = new();
      strides        = '{3'd4, 3'd7, 3'd0, 3'd2, 3'd3, 3'd1};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      req.valid      = 1'b0;
      req.in_byte    = '0;
      req.plane      = '0;
      req.last       = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      csr_access(1'b0, StrideOffset, '0, rd);
      if (rd[sprle_pkg::StrideW-1:0] !== sprle_pkg::StrideReset) begin
         tracker.flag($sformatf("stride reset value %0d", rd[sprle_pkg::StrideW-1:0]));
      end

      // directed: shortest literal, run extremes including a run of 129, cut segments
      send_byte(8'h00, 2'd0, 1'b0);
      send_byte(8'h00, 2'd0, 1'b0);
      send_byte(8'h02, 2'd3, 1'b0);
      send_byte(8'hff, 2'd3, 1'b0);
      send_byte(8'h80, 2'd3, 1'b0);
      send_byte(8'h7f, 2'd3, 1'b0);
      send_byte(8'h80, 2'd2, 1'b0);
      send_byte(8'hab, 2'd2, 1'b0);
      send_byte(8'hff, 2'd1, 1'b0);
      send_byte(8'h55, 2'd1, 1'b0);
      send_byte(8'h81, 2'd0, 1'b0);
      send_byte(8'hff, 2'd0, 1'b1);
      send_byte(8'h05, 2'd2, 1'b1);
      send_byte(8'h03, 2'd1, 1'b0);
      send_byte(8'h12, 2'd1, 1'b0);
      send_byte(8'h34, 2'd1, 1'b1);
      send_byte(8'hc0, 2'd3, 1'b0);
      send_byte(8'h00, 2'd3, 1'b1);
      send_byte(8'h01, 2'd2, 1'b0);
      send_byte(8'h77, 2'd2, 1'b0);
      send_byte(8'h88, 2'd2, 1'b1);
      send_byte(8'h80, 2'd0, 1'b1);

      for (int seg = 0; seg < 6; seg++) begin
         set_stride(strides[seg]);
         set_idling(seg % 4);
         send_random(140);
         await_writes();
         send_random(145);
      end

      set_idling(0);
      send_byte(8'h01, 2'd3, 1'b0);
      send_byte(8'h5a, 2'd3, 1'b0);
      send_byte(8'ha5, 2'd0, 1'b1);

      await_writes();
      repeat (DrainCycles) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("strided_packbits_rle_decoder_unit_test OK");
      end else begin
         $display("strided_packbits_rle_decoder_unit_test NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sprle_pkg.sv
rtl/sprle_channels.sv
rtl/strided_packbits_rle_decoder_unit.sv
rtl/sprle_checker.sv
bench/strided_packbits_rle_decoder_unit_test.sv
